[rtl/cct_pkg.sv]
// Shared types and constants of the Collatz crossing-time block.
`default_nettype none

package cct_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_TIMEOUT  = 2'd2
   } status_type;

   // Register select, taken from address bit 3 (registers lie 8 bytes apart).
   localparam logic CSR_LOWER_BOUND = 1'b0;
   localparam logic CSR_STEP_LIMIT  = 1'b1;

   localparam int unsigned CSR_ADDR_WIDTH = 4;

   // Reset values of the registers.
   localparam logic [63:0] LOWER_BOUND_RESET = 64'd16;
   localparam logic [31:0] STEP_LIMIT_RESET  = 32'd65535;

   // Largest value whose 3x+1 still fits in 64 bits.
   localparam logic [63:0] TRIPLE_MAX = (64'hFFFF_FFFF_FFFF_FFFF - 64'd1) / 64'd3;

endpackage : cct_pkg

`default_nettype wire

[rtl/collatz_crossing_time.sv]
// Collatz crossing-time engine: iterates the Collatz map on one start value at a time.
//
// Usage:
//   A start value enters on the req_ channel (valid/ready). The engine then
//   applies one map step per clock (halve if even, 3x+1 if odd) until the
//   value falls below the lower_bound register, the step_limit register is
//   reached (timeout status) or a 3x+1 step would overflow 64 bits (overflow
//   status). One result transaction per start value leaves on the rsp_ channel
//   carrying the start value, step count, largest value seen and status.
// Step loop:
//   A trajectory stays in the step loop until a termination test holds; the
//   result is valid in the cycle after, and req_ready rises again at the same
//   time, so no new start value is taken while an item is in the loop. All
//   steps use the single step unit (one 64-bit shift-and-add plus compares).
// Stalls:
//   The result sits in an output register; the next item can be accepted and
//   worked on while it waits. An item that finishes while the previous result
//   is still untaken holds in the loop until the output register frees.
// Reset:
//   A synchronous, active-high reset returns the engine to idle, drops
//   rsp_valid and restores lower_bound to 16 and step_limit to 65535.
// Registers (APB, 64-bit data): lower_bound at 0x0, step_limit at 0x8.
`default_nettype none

module collatz_crossing_time
   import cct_pkg::*;
#(
   parameter int unsigned STEP_WIDTH = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   // Input channel
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire  [63:0]               req_start_value,
   // Result channel
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic [63:0]               rsp_start_echo,
   output logic [31:0]               rsp_step_count,
   output logic [63:0]               rsp_max_reached,
   output logic [1:0]                rsp_status,
   // Configuration port
   input  wire                       csr_psel,
   input  wire                       csr_penable,
   input  wire                       csr_pwrite,
   input  wire  [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire  [63:0]               csr_pwdata,
   output logic [63:0]               csr_prdata,
   output logic                      csr_pready
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam logic [63:0] STEP_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - STEP_WIDTH);

   state_type             state_ff,        state_in;
   logic [63:0]           lower_bound_ff,  lower_bound_in;
   logic [31:0]           step_limit_ff,   step_limit_in;
   logic [63:0]           cur_ff,          cur_in;
   logic [63:0]           max_ff,          max_in;
   logic [STEP_WIDTH-1:0] steps_ff,        steps_in;
   logic [STEP_WIDTH-1:0] limit_ff,        limit_in;
   logic [63:0]           start_ff,        start_in;
   logic                  rsp_valid_ff,    rsp_valid_in;
   logic [63:0]           rsp_start_ff,    rsp_start_in;
   logic [31:0]           rsp_steps_ff,    rsp_steps_in;
   logic [63:0]           rsp_max_ff,      rsp_max_in;
   status_type            rsp_status_ff,   rsp_status_in;

   logic        csr_write;
   logic [63:0] limit_ext;
   logic [63:0] limit_eff;
   logic [63:0] triple;
   logic [63:0] max_fold;
   logic [63:0] steps_wide;
   logic        finish;
   status_type  finish_status;
   logic        out_free;

   // Configuration write strobe and read mux.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3])
         CSR_LOWER_BOUND: csr_prdata = lower_bound_ff;
         CSR_STEP_LIMIT:  csr_prdata = {32'd0, step_limit_ff};
         default:         csr_prdata = 64'd0;
      endcase
   end

   // Step limit saturated to what the step counter can hold.
   assign limit_ext = {32'd0, step_limit_ff};
   assign limit_eff = (limit_ext > STEP_MASK) ? STEP_MASK : limit_ext;

   // Shared step unit: 3x+1 as a shift and add, and the running maximum fold.
   assign triple   = {cur_ff[62:0], 1'b0} + cur_ff + 64'd1;
   assign max_fold = (cur_ff > max_ff) ? cur_ff : max_ff;

   // Termination tests in the order bound, step limit, overflow.
   always_comb begin
      finish        = 1'b1;
      finish_status = STATUS_DONE;
      priority if (cur_ff < lower_bound_ff) begin
         finish_status = STATUS_DONE;
      end else if (steps_ff >= limit_ff) begin
         finish_status = STATUS_TIMEOUT;
      end else if (cur_ff[0] && (cur_ff > TRIPLE_MAX)) begin
         finish_status = STATUS_OVERFLOW;
      end else begin
         finish = 1'b0;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign steps_wide = 64'(steps_ff);

   // Next-state logic of the sequencer, the working registers and the output register.
   always_comb begin
      state_in       = state_ff;
      lower_bound_in = lower_bound_ff;
      step_limit_in  = step_limit_ff;
      cur_in         = cur_ff;
      max_in         = max_ff;
      steps_in       = steps_ff;
      limit_in       = limit_ff;
      start_in       = start_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_steps_in   = rsp_steps_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_write) begin
         unique case (csr_paddr[3])
            CSR_LOWER_BOUND: lower_bound_in = csr_pwdata;
            CSR_STEP_LIMIT:  step_limit_in  = csr_pwdata[31:0];
            default:         lower_bound_in = lower_bound_ff;
         endcase
      end

      // The result transaction leaves when the receiver takes it.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in   = req_start_value;
               max_in   = req_start_value;
               start_in = req_start_value;
               steps_in = '0;
               limit_in = limit_eff[STEP_WIDTH-1:0];
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // The maximum is folded from the registered value, so it trails the value; folding is idempotent.
            max_in = max_fold;
            if (finish) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_start_in  = start_ff;
                  rsp_steps_in  = steps_wide[31:0];
                  rsp_max_in    = max_fold;
                  rsp_status_in = finish_status;
                  state_in      = ST_IDLE;
               end
            end else begin
               cur_in   = cur_ff[0] ? triple : {1'b0, cur_ff[63:1]};
               steps_in = steps_ff + STEP_WIDTH'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         lower_bound_ff <= LOWER_BOUND_RESET;
         step_limit_ff  <= STEP_LIMIT_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         lower_bound_ff <= lower_bound_in;
         step_limit_ff  <= step_limit_in;
      end
      cur_ff        <= cur_in;
      max_ff        <= max_in;
      steps_ff      <= steps_in;
      limit_ff      <= limit_in;
      start_ff      <= start_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_steps_ff  <= rsp_steps_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_start_echo  = rsp_start_ff;
   assign rsp_step_count  = rsp_steps_ff;
   assign rsp_max_reached = rsp_max_ff;
   assign rsp_status      = rsp_status_ff;

endmodule : collatz_crossing_time

`default_nettype wire

[rtl/cct_checker.sv]
// Port-level checker of the Collatz crossing-time block, bound to the top level.
`default_nettype none

module cct_checker
   import cct_pkg::*;
(
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire [63:0]                rsp_start_echo,
   input wire [31:0]                rsp_step_count,
   input wire [63:0]                rsp_max_reached,
   input wire [1:0]                 rsp_status
);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_echo)
         && $stable(rsp_step_count) && $stable(rsp_max_reached) && $stable(rsp_status))
      else $error("result changed while stalled");

   // The engine is not ready in the cycle after it takes a start value.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine ready directly after accepting a transaction");

   // The maximum includes the start value, and the spare status code never appears.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_max_reached >= rsp_start_echo)
         && (rsp_status <= STATUS_TIMEOUT))
      else $error("result maximum below start value or bad status");

   // An overflow can only be reported once the trajectory passed the 3x+1 limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_OVERFLOW) |-> rsp_max_reached > TRIPLE_MAX)
      else $error("overflow reported below the 3x+1 limit");

endmodule : cct_checker

bind collatz_crossing_time cct_checker u_cct_checker (.*);

`default_nettype wire
